FILE: rtl/spp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the spectral peak picker.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int MAG_W    = 24;
  localparam int CPX_W    = 25;
  localparam int BIN_W    = 13;
  localparam int IDX_W    = 12;
  localparam int PC_W     = 5;
  localparam int NUM_W    = 4;
  localparam int PHASE_W  = 16;
  localparam int THR_W    = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam int WINDOW_DEF    = 10;
  localparam int HALF_SPAN_DEF = 5;

  localparam int QDEPTH = 4;

  localparam int CORDIC_N = 16;
  localparam int XW       = 36;
  localparam int AW       = 22;

  localparam logic [BIN_W-1:0] BIN_MAX = 13'd8191;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PEAKS      = 2'd2;

  localparam logic [BIN_W-1:0] SCAN_LENGTH_RST    = 13'd2048;
  localparam logic [THR_W-1:0] PEAK_THRESHOLD_RST = 24'd410;
  localparam logic [PC_W-1:0]  MAX_PEAKS_RST      = 5'd16;

  localparam int CordicAtan [CORDIC_N] = '{
    262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
    1304, 652, 326, 163, 81, 41, 20, 10
  };

  typedef struct packed {
    logic [IDX_W-1:0]        bin;
    logic [MAG_W-1:0]        mag;
    logic signed [CPX_W-1:0] re;
    logic signed [CPX_W-1:0] im;
    logic [NUM_W-1:0]        num;
  } peak_rec_t;

endpackage
`default_nettype wire

FILE: rtl/spp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_queue
// Small FIFO of accepted peaks between detection and phase computation.
// ----------------------------------------------------------------------------
module spp_queue
  import spp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire peak_rec_t wdata,
  input  wire logic      pop,
  output peak_rec_t      rdata,
  output logic           empty,
  output logic           room
);

  localparam int PW = $clog2(QDEPTH);

  peak_rec_t        mem [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign empty = (count == '0);
  assign room  = (count < (PW+1)'(QDEPTH - 1));
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_front
// Accept bins, keep sliding history and sum, pick window maxima, qualify peaks.
// ----------------------------------------------------------------------------
module spp_front
  import spp_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int HALF_SPAN = HALF_SPAN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [MAG_W-1:0]    magnitude,
  input  wire logic [CPX_W-1:0]    real_part,
  input  wire logic [CPX_W-1:0]    imag_part,
  input  wire logic                frame_start,
  input  wire logic [BIN_W-1:0]    scan_length,
  input  wire logic [THR_W-1:0]    peak_threshold,
  input  wire logic [PC_W-1:0]     max_peaks,
  input  wire logic                room,
  output logic                     push,
  output peak_rec_t                rec
);

  localparam int LOOK    = (HALF_SPAN > 2) ? HALF_SPAN - 1 : 1;
  localparam int NH      = 2 * HALF_SPAN;
  localparam int SUM_W   = MAG_W + $clog2(NH);
  localparam int CW      = MAG_W + 8;
  localparam int WPW     = $clog2(WINDOW);
  localparam int P0      = (WINDOW - (LOOK % WINDOW)) % WINDOW;
  localparam bit SUM_OLD = (HALF_SPAN == 1);

  logic                 acc;
  logic [BIN_W-1:0]     bin_cnt;
  logic [BIN_W-1:0]     b;
  logic [BIN_W-1:0]     j;
  logic [WPW-1:0]       wpos;
  logic [WPW-1:0]       wpos_eff;
  logic [MAG_W-1:0]     mhist [NH];
  logic [CPX_W-1:0]     rehist [LOOK];
  logic [CPX_W-1:0]     imhist [LOOK];
  logic [MAG_W-1:0]     taps [NH+1];
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_eff;
  logic [SUM_W-1:0]     sum_next;

  logic                 c1_v;
  logic                 c1_fs;
  logic                 c1_start;
  logic                 c1_end;
  logic [IDX_W-1:0]     c1_j;
  logic [MAG_W-1:0]     c1_mag;
  logic [MAG_W-1:0]     c1_prev;
  logic [MAG_W-1:0]     c1_nxt;
  logic [SUM_W-1:0]     c1_sum;
  logic [CPX_W-1:0]     c1_re;
  logic [CPX_W-1:0]     c1_im;

  logic [IDX_W-1:0]     best_idx;
  logic [MAG_W-1:0]     best_mag;
  logic                 best_ok;
  logic [CPX_W-1:0]     best_re;
  logic [CPX_W-1:0]     best_im;

  logic [PC_W-1:0]      peak_cnt;
  logic [PC_W-1:0]      pc_eff;
  logic                 c_ok;
  logic                 take;
  logic [IDX_W-1:0]     nb_idx;
  logic [MAG_W-1:0]     nb_mag;
  logic                 nb_ok;
  logic [CPX_W-1:0]     nb_re;
  logic [CPX_W-1:0]     nb_im;

  assign in_ready = room;
  assign acc      = in_valid & room;

  assign b        = frame_start ? '0 : bin_cnt;
  assign j        = b - BIN_W'(LOOK);
  assign wpos_eff = frame_start ? WPW'(P0) : wpos;
  assign sum_eff  = frame_start ? '0 : sum;

  always_comb begin
    taps[0] = magnitude;
    for (int k = 0; k < NH; k++) begin
      taps[k+1] = frame_start ? '0 : mhist[k];
    end
  end

  assign sum_next = sum_eff + SUM_W'(magnitude) - SUM_W'(taps[NH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_cnt <= '0;
      wpos    <= WPW'(P0);
      sum     <= '0;
      for (int k = 0; k < NH; k++) mhist[k] <= '0;
    end else if (acc) begin
      bin_cnt <= (b == BIN_MAX) ? b : b + 1'b1;
      wpos    <= (wpos_eff == WPW'(WINDOW - 1)) ? '0 : wpos_eff + 1'b1;
      sum     <= sum_next;
      for (int k = 0; k < NH; k++) mhist[k] <= taps[k];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rehist[0] <= real_part;
      imhist[0] <= imag_part;
      for (int k = 1; k < LOOK; k++) begin
        rehist[k] <= rehist[k-1];
        imhist[k] <= imhist[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else begin
      c1_v <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      c1_fs    <= frame_start;
      c1_start <= (wpos_eff == WPW'(1));
      c1_end   <= (wpos_eff == '0) && (b >= BIN_W'(LOOK + WINDOW)) &&
                  (j < scan_length) && (b != BIN_MAX);
      c1_j     <= j[IDX_W-1:0];
      c1_mag   <= taps[LOOK];
      c1_prev  <= taps[LOOK+1];
      c1_nxt   <= taps[LOOK-1];
      c1_sum   <= SUM_OLD ? sum_eff : sum_next;
      c1_re    <= rehist[LOOK-1];
      c1_im    <= imhist[LOOK-1];
    end
  end

  assign c_ok = (c1_mag >= c1_prev) && (c1_mag >= c1_nxt) &&
                (c1_mag > peak_threshold) &&
                ((CW'(c1_sum) * CW'(3)) < (CW'(c1_mag) * CW'(4 * HALF_SPAN)));

  assign take   = c1_start || (c1_mag > best_mag);
  assign nb_idx = take ? c1_j   : best_idx;
  assign nb_mag = take ? c1_mag : best_mag;
  assign nb_ok  = take ? c_ok   : best_ok;
  assign nb_re  = take ? c1_re  : best_re;
  assign nb_im  = take ? c1_im  : best_im;
  assign pc_eff = c1_fs ? '0 : peak_cnt;

  assign push = c1_v && c1_end && nb_ok && (pc_eff < max_peaks);

  always_comb begin
    rec.bin = nb_idx;
    rec.mag = nb_mag;
    rec.re  = nb_re;
    rec.im  = nb_im;
    rec.num = pc_eff[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (c1_v) begin
      best_idx <= nb_idx;
      best_mag <= nb_mag;
      best_ok  <= nb_ok;
      best_re  <= nb_re;
      best_im  <= nb_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_cnt <= '0;
    end else if (c1_v) begin
      peak_cnt <= push ? pc_eff + 1'b1 : pc_eff;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_back
// Pipelined vectoring CORDIC for peak phase, and the result register.
// ----------------------------------------------------------------------------
module spp_back
  import spp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire peak_rec_t         qdata,
  input  wire logic              qempty,
  output logic                   qpop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       bin_index,
  output logic [MAG_W-1:0]       peak_magnitude,
  output logic [PHASE_W-1:0]     phase,
  output logic [NUM_W-1:0]       peak_number
);

  logic                    en;
  logic signed [XW-1:0]    xr;
  logic signed [XW-1:0]    yr;
  logic signed [XW-1:0]    x0;
  logic signed [XW-1:0]    y0;
  logic signed [AW-1:0]    a0;
  logic signed [AW-1:0]    rnd;

  logic                    v   [CORDIC_N+1];
  logic signed [XW-1:0]    x   [CORDIC_N+1];
  logic signed [XW-1:0]    y   [CORDIC_N+1];
  logic signed [AW-1:0]    a   [CORDIC_N+1];
  logic [IDX_W-1:0]        sbin [CORDIC_N+1];
  logic [MAG_W-1:0]        smag [CORDIC_N+1];
  logic [NUM_W-1:0]        snum [CORDIC_N+1];
  logic                    szero [CORDIC_N+1];

  assign en   = !out_valid || out_ready;
  assign qpop = en && !qempty;

  assign xr = {{(XW-CPX_W-8){qdata.re[CPX_W-1]}}, qdata.re, 8'b0};
  assign yr = {{(XW-CPX_W-8){qdata.im[CPX_W-1]}}, qdata.im, 8'b0};

  always_comb begin
    if (xr < 0) begin
      if (yr >= 0) begin
        x0 = yr;
        y0 = -xr;
        a0 = AW'(524288);
      end else begin
        x0 = -yr;
        y0 = xr;
        a0 = -AW'(524288);
      end
    end else begin
      x0 = xr;
      y0 = yr;
      a0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_N; k++) v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v[0] <= qpop;
      for (int k = 0; k < CORDIC_N; k++) v[k+1] <= v[k];
      out_valid <= v[CORDIC_N];
    end
  end

  assign rnd = a[CORDIC_N] + AW'(16);

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]     <= x0;
      y[0]     <= y0;
      a[0]     <= a0;
      sbin[0]  <= qdata.bin;
      smag[0]  <= qdata.mag;
      snum[0]  <= qdata.num;
      szero[0] <= (qdata.re == '0) && (qdata.im == '0);
      for (int k = 0; k < CORDIC_N; k++) begin
        if (y[k] >= 0) begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          a[k+1] <= a[k] + AW'(CordicAtan[k]);
        end else begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          a[k+1] <= a[k] - AW'(CordicAtan[k]);
        end
        sbin[k+1]  <= sbin[k];
        smag[k+1]  <= smag[k];
        snum[k+1]  <= snum[k];
        szero[k+1] <= szero[k];
      end
      bin_index      <= sbin[CORDIC_N];
      peak_magnitude <= smag[CORDIC_N];
      peak_number    <= snum[CORDIC_N];
      phase          <= szero[CORDIC_N] ? '0 : rnd[PHASE_W+4:5];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spectral_peak_picker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A peak appears on the master side once the bin that closes its decision is accepted and
// has passed the detection register, the peak queue, 17 CORDIC stages and the result register.
// Throughput: one bin per cycle while the peak queue has room; the 4-entry peak queue
// and the result register let detection keep running while a result waits.
// Reset: synchronous, clears counters, magnitude history, queue and valids; configuration
// returns to scan length 2048, threshold 410, 16 peaks.
// ----------------------------------------------------------------------------
// spectral_peak_picker_core
// Streaming FFT peak picker with window maxima, prominence test and phase.
// ----------------------------------------------------------------------------
module spectral_peak_picker_core
  import spp_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int HALF_SPAN = HALF_SPAN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // magnitude[23:0], real_part[48:24], imag_part[73:49], zero fill
  input  wire logic [79:0]          s_tdata,
  // frame_start[0]
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // bin_index[11:0], peak_magnitude[35:12], phase[51:36], peak_number[55:52]
  output logic [55:0]               m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [BIN_W-1:0]   scan_length;
  logic [THR_W-1:0]   peak_threshold;
  logic [PC_W-1:0]    max_peaks;
  logic               room;
  logic               push;
  peak_rec_t          rec;
  peak_rec_t          qdata;
  logic               qempty;
  logic               qpop;
  logic [IDX_W-1:0]   bin_index;
  logic [MAG_W-1:0]   peak_magnitude;
  logic [PHASE_W-1:0] phase;
  logic [NUM_W-1:0]   peak_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_length    <= SCAN_LENGTH_RST;
      peak_threshold <= PEAK_THRESHOLD_RST;
      max_peaks      <= MAX_PEAKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_LENGTH:    scan_length    <= cfg_data[BIN_W-1:0];
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[THR_W-1:0];
        REG_MAX_PEAKS:      max_peaks      <= cfg_data[PC_W-1:0];
        default: ;
      endcase
    end
  end

  spp_front #(
    .WINDOW    (WINDOW),
    .HALF_SPAN (HALF_SPAN)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .magnitude      (s_tdata[23:0]),
    .real_part      (s_tdata[48:24]),
    .imag_part      (s_tdata[73:49]),
    .frame_start    (s_tuser),
    .scan_length    (scan_length),
    .peak_threshold (peak_threshold),
    .max_peaks      (max_peaks),
    .room           (room),
    .push           (push),
    .rec            (rec)
  );

  spp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (rec),
    .pop   (qpop),
    .rdata (qdata),
    .empty (qempty),
    .room  (room)
  );

  spp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .qdata          (qdata),
    .qempty         (qempty),
    .qpop           (qpop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .bin_index      (bin_index),
    .peak_magnitude (peak_magnitude),
    .phase          (phase),
    .peak_number    (peak_number)
  );

  assign m_tdata = {peak_number, phase, peak_magnitude, bin_index};

endmodule
`default_nettype wire

FILE: rtl/spp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks of the peak picker, bound to the top level.
// ----------------------------------------------------------------------------
module spp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  a_peak_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[35:12] != 24'd0)
    else $error("peak with zero magnitude");

endmodule

bind spectral_peak_picker_core spp_checker u_spp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
